// ===== sv/periodic_cell_minimum_image_macros.svh =====
// Assertion helpers for the minimum-image block.
`ifndef PERIODIC_CELL_MINIMUM_IMAGE_MACROS_SVH
`define PERIODIC_CELL_MINIMUM_IMAGE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PCMI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCMI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pcmi_pkg.sv =====
package pcmi_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int PW  = 2 * WORD_BITS;
    localparam int NW  = 2 * WORD_BITS + 1;
    localparam int DW  = 2 * WORD_BITS;
    localparam int MW  = 2 * WORD_BITS + 1;
    localparam int TW  = 2 * WORD_BITS + 1;
    localparam int TSW = 2 * WORD_BITS + 2;
    localparam int RW  = 2 * WORD_BITS;
    localparam int XW  = 3 * WORD_BITS;
    localparam int OSW = 3 * WORD_BITS + 2;
    localparam int OMW = 3 * WORD_BITS + 1;
    localparam int QB  = WORD_BITS + 1;
    localparam int IDX_BITS = 8;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [IDX_BITS-1:0] reg_idx_t;

    localparam reg_idx_t REG_BASIS1_X = reg_idx_t'(0);
    localparam reg_idx_t REG_BASIS1_Y = reg_idx_t'(1);
    localparam reg_idx_t REG_BASIS2_X = reg_idx_t'(2);
    localparam reg_idx_t REG_BASIS2_Y = reg_idx_t'(3);

    localparam word_t BASIS_ONE  = word_t'(1 << FRAC_BITS);
    localparam word_t BASIS_ZERO = word_t'(0);

    typedef struct packed {
        word_t b1x;
        word_t b1y;
        word_t b2x;
        word_t b2y;
    } basis_t;

    typedef struct packed {
        logic          valid;
        logic          singular;
        logic [DW-1:0] d_mag;
        logic          t1_neg;
        logic [TW-1:0] t1_mag;
        logic          t2_neg;
        logic [TW-1:0] t2_mag;
    } front_t;

    typedef struct packed {
        logic          singular;
        logic [DW-1:0] d_mag;
        logic          t1_neg;
        logic [TW-1:0] t1_mag;
        logic          t2_neg;
        logic [TW-1:0] t2_mag;
        logic [MW-1:0] rem1;
        logic [MW-1:0] rem2;
    } red_stage_t;

    typedef struct packed {
        logic                 valid;
        logic                 singular;
        logic [DW-1:0]        d_mag;
        logic signed [RW-1:0] r1;
        logic signed [RW-1:0] r2;
    } red_t;

    typedef struct packed {
        logic          singular;
        logic [DW-1:0] d_mag;
    } side_t;

    typedef struct packed {
        side_t         side;
        logic          negx;
        logic [QB-1:0] lox;
        logic [MW-1:0] remx;
        logic [QB-1:0] qx;
        logic          negy;
        logic [QB-1:0] loy;
        logic [MW-1:0] remy;
        logic [QB-1:0] qy;
    } div_stage_t;

    typedef struct packed {
        logic  valid;
        word_t wrapped_x;
        word_t wrapped_y;
        logic  singular;
    } res_t;

    // One restoring step: shift in a bit, subtract the modulus when it fits.
    function automatic logic [MW:0] div_step(input logic [MW-1:0] rem, input logic din,
                                             input logic [MW-1:0] modulus);
        logic [MW:0] sh;
        logic [MW:0] diff;
        begin
            sh = {rem, din};
            diff = sh - {1'b0, modulus};
            if (sh >= {1'b0, modulus})
            begin
                return {1'b1, diff[MW-1:0]};
            end
            return {1'b0, sh[MW-1:0]};
        end
    endfunction

    function automatic word_t sat_word(input logic signed [QB+1:0] v);
        logic [QB+2-WORD_BITS:0] top;
        begin
            top = v[QB+1:WORD_BITS-1];
            if (top == '0 || top == '1)
            begin
                return v[WORD_BITS-1:0];
            end
            if (v[QB+1])
            begin
                return {1'b1, {(WORD_BITS-1){1'b0}}};
            end
            return {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    endfunction

endpackage

// ===== sv/pcmi_vec_if.sv =====
interface pcmi_vec_if import pcmi_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t vec_x;
    word_t vec_y;

    modport source (output valid, output vec_x, output vec_y, input ready);
    modport sink (input valid, input vec_x, input vec_y, output ready);
endinterface

// ===== sv/pcmi_res_if.sv =====
interface pcmi_res_if import pcmi_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t wrapped_x;
    word_t wrapped_y;
    logic  singular_basis;

    modport source (output valid, output wrapped_x, output wrapped_y,
                    output singular_basis, input ready);
    modport sink (input valid, input wrapped_x, input wrapped_y,
                  input singular_basis, output ready);
endinterface

// ===== sv/pcmi_cfg_if.sv =====
interface pcmi_cfg_if import pcmi_pkg::*; ();
    logic     valid;
    logic     ready;
    reg_idx_t index;
    word_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/pcmi_front.sv =====
module pcmi_front import pcmi_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  logic   in_valid,
    input  word_t  vec_x,
    input  word_t  vec_y,
    input  basis_t basis,
    output front_t front
);

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;

    logic signed [PW-1:0] p_ad_reg, p_bc_reg, p_dx_reg, p_by_reg, p_ay_reg, p_cx_reg;
    logic signed [PW-1:0] p_ad_next, p_bc_next, p_dx_next, p_by_next, p_ay_next, p_cx_next;

    logic signed [NW-1:0] det_reg, n1_reg, n2_reg;
    logic signed [NW-1:0] det_next, n1_next, n2_next;

    logic                 sing3_reg, sing3_next;
    logic [DW-1:0]        dmag3_reg, dmag3_next;
    logic signed [NW-1:0] n1n_reg, n2n_reg, n1n_next, n2n_next;

    logic                  sing4_reg;
    logic [DW-1:0]         dmag4_reg;
    logic signed [TSW-1:0] t1_reg, t2_reg, t1_next, t2_next;

    front_t front_reg, front_next;

    always_comb
    begin
        p_ad_next = basis.b1x * basis.b2y;
        p_bc_next = basis.b2x * basis.b1y;
        p_dx_next = basis.b2y * vec_x;
        p_by_next = basis.b2x * vec_y;
        p_ay_next = basis.b1x * vec_y;
        p_cx_next = basis.b1y * vec_x;
    end

    always_comb
    begin
        det_next = NW'(p_ad_reg) - NW'(p_bc_reg);
        n1_next  = NW'(p_dx_reg) - NW'(p_by_reg);
        n2_next  = NW'(p_ay_reg) - NW'(p_cx_reg);
    end

    always_comb
    begin
        sing3_next = (det_reg == '0);
        dmag3_next = DW'(det_reg[NW-1] ? -det_reg : det_reg);
        n1n_next   = det_reg[NW-1] ? -n1_reg : n1_reg;
        n2n_next   = det_reg[NW-1] ? -n2_reg : n2_reg;
    end

    always_comb
    begin
        t1_next = (TSW'(n1n_reg) <<< 1) + TSW'({1'b0, dmag3_reg});
        t2_next = (TSW'(n2n_reg) <<< 1) + TSW'({1'b0, dmag3_reg});
    end

    always_comb
    begin
        front_next.valid    = s4_valid_reg;
        front_next.singular = sing4_reg;
        front_next.d_mag    = dmag4_reg;
        front_next.t1_neg   = t1_reg[TSW-1];
        front_next.t1_mag   = TW'(t1_reg[TSW-1] ? -t1_reg : t1_reg);
        front_next.t2_neg   = t2_reg[TSW-1];
        front_next.t2_mag   = TW'(t2_reg[TSW-1] ? -t2_reg : t2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_ad_reg  <= p_ad_next;
            p_bc_reg  <= p_bc_next;
            p_dx_reg  <= p_dx_next;
            p_by_reg  <= p_by_next;
            p_ay_reg  <= p_ay_next;
            p_cx_reg  <= p_cx_next;
            det_reg   <= det_next;
            n1_reg    <= n1_next;
            n2_reg    <= n2_next;
            sing3_reg <= sing3_next;
            dmag3_reg <= dmag3_next;
            n1n_reg   <= n1n_next;
            n2n_reg   <= n2n_next;
            sing4_reg <= sing3_reg;
            dmag4_reg <= dmag3_reg;
            t1_reg    <= t1_next;
            t2_reg    <= t2_next;
            front_reg <= front_next;
        end
    end

    always_comb
    begin
        front = front_reg;
        front.valid = s5_valid_reg;
    end

endmodule

// ===== sv/pcmi_modred.sv =====
module pcmi_modred import pcmi_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  front_t front,
    output red_t   red
);

    red_stage_t    stg_in [TW];
    red_stage_t    stg_next [TW];
    red_stage_t    stg_reg [TW];
    logic [TW-1:0] vld_reg;

    logic                 last_valid_reg;
    red_t                 red_reg, red_next;
    logic [MW-1:0]        modulus;
    logic [MW-1:0]        m1, m2;
    logic signed [MW:0]   c1, c2;

    always_comb
    begin
        stg_in[0].singular = front.singular;
        stg_in[0].d_mag    = front.d_mag;
        stg_in[0].t1_neg   = front.t1_neg;
        stg_in[0].t1_mag   = front.t1_mag;
        stg_in[0].t2_neg   = front.t2_neg;
        stg_in[0].t2_mag   = front.t2_mag;
        stg_in[0].rem1     = '0;
        stg_in[0].rem2     = '0;
    end

    for (genvar k = 0; k < TW; k++)
    begin : g_stage
        logic [MW:0] s1, s2;

        if (k > 0)
        begin : g_link
            assign stg_in[k] = stg_reg[k-1];
        end

        always_comb
        begin
            s1 = div_step(stg_in[k].rem1, stg_in[k].t1_mag[TW-1-k],
                          {stg_in[k].d_mag, 1'b0});
            s2 = div_step(stg_in[k].rem2, stg_in[k].t2_mag[TW-1-k],
                          {stg_in[k].d_mag, 1'b0});
            stg_next[k] = stg_in[k];
            stg_next[k].rem1 = s1[MW-1:0];
            stg_next[k].rem2 = s2[MW-1:0];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                stg_reg[k] <= stg_next[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            last_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg        <= {vld_reg[TW-2:0], front.valid};
            last_valid_reg <= vld_reg[TW-1];
        end
    end

    // Floor remainder of 2n + D by 2D, then the centered remainder (m - D) / 2.
    always_comb
    begin
        modulus = {stg_reg[TW-1].d_mag, 1'b0};
        m1 = (stg_reg[TW-1].t1_neg && stg_reg[TW-1].rem1 != '0)
             ? modulus - stg_reg[TW-1].rem1 : stg_reg[TW-1].rem1;
        m2 = (stg_reg[TW-1].t2_neg && stg_reg[TW-1].rem2 != '0)
             ? modulus - stg_reg[TW-1].rem2 : stg_reg[TW-1].rem2;
        c1 = $signed({1'b0, m1}) - $signed({2'b00, stg_reg[TW-1].d_mag});
        c2 = $signed({1'b0, m2}) - $signed({2'b00, stg_reg[TW-1].d_mag});
        red_next.valid    = vld_reg[TW-1];
        red_next.singular = stg_reg[TW-1].singular;
        red_next.d_mag    = stg_reg[TW-1].d_mag;
        red_next.r1       = RW'(c1 >>> 1);
        red_next.r2       = RW'(c2 >>> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg <= red_next;
        end
    end

    always_comb
    begin
        red = red_reg;
        red.valid = last_valid_reg;
    end

endmodule

// ===== sv/pcmi_recomb.sv =====
module pcmi_recomb import pcmi_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   adv,
    input  red_t   red,
    input  basis_t basis,
    output res_t   result
);

    logic sa_valid_reg, sb_valid_reg, sc_valid_reg, sd_valid_reg;
    logic out_valid_reg;

    side_t sa_side_reg, sb_side_reg, sc_side_reg, sd_side_reg;

    logic signed [PW:0]   pa_lo_reg, pb_lo_reg, pc_lo_reg, pd_lo_reg;
    logic signed [PW-1:0] pa_hi_reg, pb_hi_reg, pc_hi_reg, pd_hi_reg;
    logic signed [PW:0]   pa_lo_next, pb_lo_next, pc_lo_next, pd_lo_next;
    logic signed [PW-1:0] pa_hi_next, pb_hi_next, pc_hi_next, pd_hi_next;

    logic signed [XW-1:0] ar_reg, br_reg, cr_reg, dr_reg;
    logic signed [XW-1:0] ar_next, br_next, cr_next, dr_next;
    logic signed [XW-1:0] nx_reg, ny_reg, nx_next, ny_next;
    logic signed [OSW-1:0] tx_reg, ty_reg, tx_next, ty_next;

    div_stage_t    dv_in [QB];
    div_stage_t    dv_next [QB];
    div_stage_t    dv_reg [QB];
    logic [QB-1:0] dv_vld_reg;

    logic [OMW-1:0]        magx, magy;
    logic signed [QB+1:0]  ox, oy;
    res_t                  res_reg, res_next;

    always_comb
    begin
        pa_lo_next = basis.b1x * $signed({1'b0, red.r1[WORD_BITS-1:0]});
        pa_hi_next = basis.b1x * $signed(red.r1[RW-1:WORD_BITS]);
        pb_lo_next = basis.b2x * $signed({1'b0, red.r2[WORD_BITS-1:0]});
        pb_hi_next = basis.b2x * $signed(red.r2[RW-1:WORD_BITS]);
        pc_lo_next = basis.b1y * $signed({1'b0, red.r1[WORD_BITS-1:0]});
        pc_hi_next = basis.b1y * $signed(red.r1[RW-1:WORD_BITS]);
        pd_lo_next = basis.b2y * $signed({1'b0, red.r2[WORD_BITS-1:0]});
        pd_hi_next = basis.b2y * $signed(red.r2[RW-1:WORD_BITS]);
    end

    always_comb
    begin
        ar_next = (XW'(pa_hi_reg) <<< WORD_BITS) + XW'(pa_lo_reg);
        br_next = (XW'(pb_hi_reg) <<< WORD_BITS) + XW'(pb_lo_reg);
        cr_next = (XW'(pc_hi_reg) <<< WORD_BITS) + XW'(pc_lo_reg);
        dr_next = (XW'(pd_hi_reg) <<< WORD_BITS) + XW'(pd_lo_reg);
        nx_next = ar_reg + br_reg;
        ny_next = cr_reg + dr_reg;
        tx_next = (OSW'(nx_reg) <<< 1) + OSW'({1'b0, sc_side_reg.d_mag});
        ty_next = (OSW'(ny_reg) <<< 1) + OSW'({1'b0, sc_side_reg.d_mag});
    end

    // The quotient fits in QB bits, so the bits above them seed the remainder.
    always_comb
    begin
        magx = OMW'(tx_reg[OSW-1] ? -tx_reg : tx_reg);
        magy = OMW'(ty_reg[OSW-1] ? -ty_reg : ty_reg);
        dv_in[0].side = sd_side_reg;
        dv_in[0].negx = tx_reg[OSW-1];
        dv_in[0].lox  = magx[QB-1:0];
        dv_in[0].remx = MW'(magx[OMW-1:QB]);
        dv_in[0].qx   = '0;
        dv_in[0].negy = ty_reg[OSW-1];
        dv_in[0].loy  = magy[QB-1:0];
        dv_in[0].remy = MW'(magy[OMW-1:QB]);
        dv_in[0].qy   = '0;
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [MW:0] sx, sy;

        if (j > 0)
        begin : g_link
            assign dv_in[j] = dv_reg[j-1];
        end

        always_comb
        begin
            sx = div_step(dv_in[j].remx, dv_in[j].lox[QB-1-j], {dv_in[j].side.d_mag, 1'b0});
            sy = div_step(dv_in[j].remy, dv_in[j].loy[QB-1-j], {dv_in[j].side.d_mag, 1'b0});
            dv_next[j] = dv_in[j];
            dv_next[j].remx = sx[MW-1:0];
            dv_next[j].qx   = {dv_in[j].qx[QB-2:0], sx[MW]};
            dv_next[j].remy = sy[MW-1:0];
            dv_next[j].qy   = {dv_in[j].qy[QB-2:0], sy[MW]};
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    always_comb
    begin
        ox = dv_reg[QB-1].negx
             ? -($signed({2'b00, dv_reg[QB-1].qx}) + (QB+2)'(dv_reg[QB-1].remx != '0))
             : $signed({2'b00, dv_reg[QB-1].qx});
        oy = dv_reg[QB-1].negy
             ? -($signed({2'b00, dv_reg[QB-1].qy}) + (QB+2)'(dv_reg[QB-1].remy != '0))
             : $signed({2'b00, dv_reg[QB-1].qy});
        res_next.valid     = dv_vld_reg[QB-1];
        res_next.singular  = dv_reg[QB-1].side.singular;
        res_next.wrapped_x = dv_reg[QB-1].side.singular ? BASIS_ZERO : sat_word(ox);
        res_next.wrapped_y = dv_reg[QB-1].side.singular ? BASIS_ZERO : sat_word(oy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sa_valid_reg  <= 1'b0;
            sb_valid_reg  <= 1'b0;
            sc_valid_reg  <= 1'b0;
            sd_valid_reg  <= 1'b0;
            dv_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sa_valid_reg  <= red.valid;
            sb_valid_reg  <= sa_valid_reg;
            sc_valid_reg  <= sb_valid_reg;
            sd_valid_reg  <= sc_valid_reg;
            dv_vld_reg    <= {dv_vld_reg[QB-2:0], sd_valid_reg};
            out_valid_reg <= dv_vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sa_side_reg <= '{singular: red.singular, d_mag: red.d_mag};
            sb_side_reg <= sa_side_reg;
            sc_side_reg <= sb_side_reg;
            sd_side_reg <= sc_side_reg;
            pa_lo_reg   <= pa_lo_next;
            pb_lo_reg   <= pb_lo_next;
            pc_lo_reg   <= pc_lo_next;
            pd_lo_reg   <= pd_lo_next;
            pa_hi_reg   <= pa_hi_next;
            pb_hi_reg   <= pb_hi_next;
            pc_hi_reg   <= pc_hi_next;
            pd_hi_reg   <= pd_hi_next;
            ar_reg      <= ar_next;
            br_reg      <= br_next;
            cr_reg      <= cr_next;
            dr_reg      <= dr_next;
            nx_reg      <= nx_next;
            ny_reg      <= ny_next;
            tx_reg      <= tx_next;
            ty_reg      <= ty_next;
            res_reg     <= res_next;
        end
    end

    always_comb
    begin
        result = res_reg;
        result.valid = out_valid_reg;
    end

endmodule

// ===== sv/periodic_cell_minimum_image.sv =====
// Minimum-image reduction of a 2D Q16.16 displacement into a periodic cell.
// The cfg channel writes the four basis registers by index (basis1_x, basis1_y,
// basis2_x, basis2_y); it is always ready, and writes to other indexes are
// dropped. Write it only while no request is inside the block.
// Each request on vec carries vec_x and vec_y; each one yields exactly one
// request on res with wrapped_x, wrapped_y and singular_basis, in order.
// A singular basis gives singular_basis high and a zero vector.
// The result is registered through the front, reduction and recombination stages,
// and one request can be accepted in every cycle unless res is stalled. The depth
// is set by the two bit-per-stage restoring reductions: the centered remainder
// against twice the determinant, and the final rounding division.
// Reset clears all valid bits and loads the unit-square basis.
// When res is stalled the whole pipeline holds and vec.ready drops in the
// same cycle; nothing is dropped or repeated.
`include "periodic_cell_minimum_image_macros.svh"

module periodic_cell_minimum_image import pcmi_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    pcmi_cfg_if.sink   cfg,
    pcmi_vec_if.sink   vec,
    pcmi_res_if.source res
);

    basis_t basis_reg;
    front_t front;
    red_t   red;
    res_t   result;
    logic   adv;

    assign adv       = !result.valid || res.ready;
    assign vec.ready = adv;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            basis_reg.b1x <= BASIS_ONE;
            basis_reg.b1y <= BASIS_ZERO;
            basis_reg.b2x <= BASIS_ZERO;
            basis_reg.b2y <= BASIS_ONE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_BASIS1_X: basis_reg.b1x <= cfg.data;
                REG_BASIS1_Y: basis_reg.b1y <= cfg.data;
                REG_BASIS2_X: basis_reg.b2x <= cfg.data;
                REG_BASIS2_Y: basis_reg.b2y <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    pcmi_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (vec.valid),
        .vec_x    (vec.vec_x),
        .vec_y    (vec.vec_y),
        .basis    (basis_reg),
        .front    (front)
    );

    pcmi_modred u_modred (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .front (front),
        .red   (red)
    );

    pcmi_recomb u_recomb (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .red    (red),
        .basis  (basis_reg),
        .result (result)
    );

    assign res.valid          = result.valid;
    assign res.wrapped_x      = result.wrapped_x;
    assign res.wrapped_y      = result.wrapped_y;
    assign res.singular_basis = result.singular;

    `PCMI_ASSERT_SAME(a_singular_zero, res.valid && res.singular_basis, res.wrapped_x == '0 && res.wrapped_y == '0, "singular basis result is not zero")
    `PCMI_ASSERT_SAME(a_stall_blocks_input, res.valid && !res.ready, !vec.ready, "input taken while output stalled")
    `PCMI_ASSERT_NEXT(a_cfg_write, cfg.valid && cfg.index == REG_BASIS1_X, basis_reg.b1x == $past(cfg.data), "basis1_x write lost")

endmodule

// ===== tb/pcmi_checker.sv =====
module pcmi_checker import pcmi_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    pcmi_cfg_if.sink        cfg,
    pcmi_vec_if.sink        vec,
    pcmi_res_if.sink        res,
    output int              fail_count,
    output int              pending_count,
    output int              result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [255:0] wide_t;

    typedef struct packed {
        word_t wx;
        word_t wy;
        logic  sing;
    } image_t;

    word_t  b1x, b1y, b2x, b2y;
    image_t image_q[$];

    function automatic wide_t floor_div(input wide_t n, input wide_t d);
        wide_t q;
        begin
            q = n / d;
            if ((n % d) != 0 && n < 0)
            begin
                q = q - 1;
            end
            return q;
        end
    endfunction

    function automatic wide_t round_div(input wide_t n, input wide_t d);
        return floor_div(2 * n + d, 2 * d);
    endfunction

    function automatic word_t clamp_word(input wide_t v);
        wide_t hi, lo;
        begin
            hi = 64'sd2147483647;
            lo = -64'sd2147483648;
            if (v > hi)
            begin
                return word_t'(hi);
            end
            if (v < lo)
            begin
                return word_t'(lo);
            end
            return word_t'(v);
        end
    endfunction

    function automatic image_t reduce_vector(input word_t vx, input word_t vy);
        wide_t a, b, c, d, x, y, det, n1, n2, r1, r2, nx, ny;
        image_t o;
        begin
            a = wide_t'(b1x);
            c = wide_t'(b1y);
            b = wide_t'(b2x);
            d = wide_t'(b2y);
            x = wide_t'(vx);
            y = wide_t'(vy);
            det = a * d - b * c;
            if (det == 0)
            begin
                o.wx = '0;
                o.wy = '0;
                o.sing = 1'b1;
                return o;
            end
            n1 = d * x - b * y;
            n2 = a * y - c * x;
            if (det < 0)
            begin
                det = -det;
                n1 = -n1;
                n2 = -n2;
            end
            r1 = n1 - round_div(n1, det) * det;
            r2 = n2 - round_div(n2, det) * det;
            nx = a * r1 + b * r2;
            ny = c * r1 + d * r2;
            o.wx = clamp_word(round_div(nx, det));
            o.wy = clamp_word(round_div(ny, det));
            o.sing = 1'b0;
            return o;
        end
    endfunction

    assign pending_count = image_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        image_t e;
        if (!rst_n)
        begin
            b1x <= BASIS_ONE;
            b1y <= BASIS_ZERO;
            b2x <= BASIS_ZERO;
            b2y <= BASIS_ONE;
            image_q.delete();
            fail_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                result_count <= result_count + 1;
                if (image_q.size() == 0)
                begin
                    if (fail_count < 10)
                    begin
                        $display("Unexpected result x=%0d y=%0d s=%0b", res.wrapped_x,
                                 res.wrapped_y, res.singular_basis);
                    end
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = image_q.pop_front();
                    if (e.wx !== res.wrapped_x || e.wy !== res.wrapped_y
                        || e.sing !== res.singular_basis)
                    begin
                        if (fail_count < 10)
                        begin
                            $display("Result error: expected x=%0d y=%0d s=%0b, got x=%0d y=%0d s=%0b",
                                     e.wx, e.wy, e.sing, res.wrapped_x, res.wrapped_y,
                                     res.singular_basis);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (vec.valid && vec.ready)
            begin
                image_q.push_back(reduce_vector(vec.vec_x, vec.vec_y));
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_BASIS1_X: b1x <= cfg.data;
                    REG_BASIS1_Y: b1y <= cfg.data;
                    REG_BASIS2_X: b2x <= cfg.data;
                    REG_BASIS2_Y: b2y <= cfg.data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== tb/tb_periodic_cell_minimum_image.sv =====
module tb_periodic_cell_minimum_image;
    timeunit 1ns;
    timeprecision 1ps;
    import pcmi_pkg::*;

    localparam int LATENCY = 3 * WORD_BITS + 12;
    localparam int CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic vec_fire, res_fire;
    int   fail_count, pending_count, result_count;
    int   cycle_count = 0;
    int   sent_count = 0;
    int   basis_sets = 0;

    pcmi_cfg_if cfg_ch();
    pcmi_vec_if vec_ch();
    pcmi_res_if res_ch();

    periodic_cell_minimum_image u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch.sink),
        .vec   (vec_ch.sink),
        .res   (res_ch.source)
    );

    pcmi_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_ch.sink),
        .vec           (vec_ch.sink),
        .res           (res_ch.sink),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .result_count  (result_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        vec_fire <= vec_ch.valid && vec_ch.ready;
        res_fire <= res_ch.valid && res_ch.ready;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", pending_count);
            $display("periodic_cell_minimum_image: mismatch");
            $finish;
        end
    end

    // The receiver stalls for a random number of cycles before each request,
    // with quiet stretches where it stays ready.
    initial
    begin
        int wait_cycles;
        res_ch.ready = 1'b0;
        @(negedge clk);
        while (1)
        begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (cycle_count % 3000 < 600)
            begin
                wait_cycles = 0;
            end
            if (wait_cycles > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(negedge clk);
            while (!res_fire) @(negedge clk);
        end
    end

    function automatic word_t random_word();
        case ($urandom_range(0, 5))
            0: return word_t'(32'h8000_0000);
            1: return word_t'(32'h7fff_ffff);
            2: return word_t'($urandom_range(0, 8) << 16) - word_t'(4 << 16);
            3: return word_t'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return word_t'($urandom());
        endcase
    endfunction

    task automatic write_basis(input reg_idx_t idx, input word_t value);
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        cfg_ch.valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_basis(input word_t ax, input word_t ay, input word_t bx, input word_t by);
        write_basis(REG_BASIS1_X, ax);
        write_basis(REG_BASIS1_Y, ay);
        write_basis(REG_BASIS2_X, bx);
        write_basis(REG_BASIS2_Y, by);
        basis_sets++;
    endtask

    task automatic send_vector(input word_t vx, input word_t vy, input bit gaps);
        int wait_cycles;
        wait_cycles = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18)) : 0;
        if (wait_cycles > 0)
        begin
            vec_ch.valid <= 1'b0;
            repeat (wait_cycles) @(negedge clk);
        end
        vec_ch.vec_x <= vx;
        vec_ch.vec_y <= vy;
        vec_ch.valid <= 1'b1;
        @(negedge clk);
        while (!vec_fire) @(negedge clk);
        sent_count++;
    endtask

    task automatic drain();
        vec_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
    endtask

    initial
    begin
        word_t ux;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        vec_ch.valid = 1'b0;
        vec_ch.vec_x = '0;
        vec_ch.vec_y = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset basis: unit square, halfway coefficients and extremes.
        send_vector(word_t'(32'h0000_8000), word_t'(32'hffff_8000), 1'b0);
        send_vector(word_t'(32'h8000_0000), word_t'(32'h7fff_ffff), 1'b0);
        send_vector(word_t'(32'h7fff_ffff), word_t'(32'h8000_0000), 1'b0);
        send_vector(word_t'(32'hffff_ffff), '0, 1'b0);
        send_vector(word_t'(32'h0001_8000), word_t'(32'h0002_7fff), 1'b0);
        drain();

        // Writes to an unmapped index must be dropped.
        write_basis(reg_idx_t'(7), word_t'(32'h1234_5678));
        write_basis(reg_idx_t'(255), '0);
        send_vector(word_t'(32'h0003_4000), word_t'(32'h0000_c000), 1'b0);
        drain();

        // Singular basis gives the flag and a zero vector.
        set_basis(word_t'(32'h0002_0000), word_t'(32'h0001_0000),
                  word_t'(32'h0004_0000), word_t'(32'h0002_0000));
        send_vector(word_t'(32'h0005_0000), word_t'(32'hfffd_0000), 1'b0);
        send_vector(word_t'(32'h7fff_ffff), word_t'(32'h8000_0000), 1'b0);
        drain();

        // Extreme basis entries, where the result saturates.
        set_basis(word_t'(32'h7fff_ffff), word_t'(32'h8000_0000),
                  word_t'(32'h8000_0000), word_t'(32'h7fff_ffff));
        send_vector(word_t'(32'h7fff_ffff), word_t'(32'h7fff_ffff), 1'b0);
        send_vector(word_t'(32'h8000_0000), word_t'(32'h0000_0001), 1'b0);
        drain();
        set_basis(word_t'(32'h8000_0000), '0, '0, word_t'(32'h0000_0001));
        send_vector(word_t'(32'h4000_0000), word_t'(32'hffff_ffff), 1'b0);
        send_vector(word_t'(32'h7fff_ffff), word_t'(32'h8000_0000), 1'b0);
        drain();

        // Negative determinant and a skewed cell.
        set_basis('0, word_t'(32'h0003_0000), word_t'(32'h0002_0000), word_t'(32'h0001_0000));
        send_vector(word_t'(32'h0001_0000), word_t'(32'h0001_8000), 1'b0);
        send_vector(word_t'(32'hfff0_0000), word_t'(32'h0011_0000), 1'b0);
        drain();

        for (int phase = 0; phase < 10; phase++)
        begin
            if (phase % 3 == 0)
            begin
                ux = word_t'($urandom_range(1, 64) << 16);
                set_basis(ux, '0, '0, word_t'($urandom_range(1, 64) << 16));
            end
            else if (phase == 5)
            begin
                ux = random_word();
                set_basis(ux, word_t'(ux <<< 1), word_t'(32'h0000_0003), word_t'(32'h0000_0006));
            end
            else
            begin
                set_basis(random_word(), random_word(), random_word(), random_word());
            end
            for (int i = 0; i < 50; i++)
            begin
                send_vector(random_word(), random_word(), 1'b1);
            end
            if (phase == 4)
            begin
                drain();
            end
            for (int i = 0; i < 20; i++)
            begin
                send_vector(random_word(), random_word(), 1'b0);
            end
            drain();
        end

        $display("Sent %0d vectors over %0d basis settings, %0d results checked.",
                 sent_count, basis_sets, result_count);
        if (fail_count == 0)
        begin
            $display("periodic_cell_minimum_image: match");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("periodic_cell_minimum_image: mismatch");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+sv
sv/pcmi_pkg.sv
sv/pcmi_vec_if.sv
sv/pcmi_res_if.sv
sv/pcmi_cfg_if.sv
sv/pcmi_front.sv
sv/pcmi_modred.sv
sv/pcmi_recomb.sv
sv/periodic_cell_minimum_image.sv
tb/pcmi_checker.sv
tb/tb_periodic_cell_minimum_image.sv
